// File: hdl/nonuniform_grid_coordinate_mapper_core_macros.svh
// Assertion helpers for the grid coordinate mapper.
`ifndef NONUNIFORM_GRID_COORDINATE_MAPPER_CORE_MACROS_SVH
`define NONUNIFORM_GRID_COORDINATE_MAPPER_CORE_MACROS_SVH
// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define NGCM_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ngcm: check failed");
// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define NGCM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ngcm: check failed");
`endif

// File: hdl/ngcm_pkg.sv
package ngcm_pkg;

  localparam int DEF_MAX_CELLS = 1024;
  localparam int CW_W   = 24;  // cell width field
  localparam int CO_W   = 40;  // coordinate field
  localparam int H2_W   = 26;  // doubled end half-width
  localparam int DNUM_W = 57;  // shifted dividend magnitude
  localparam int ACC_W  = 66;  // full product of the multiplier sequence
  localparam int MAG_W  = 58;  // result magnitude before the sign is applied
  localparam int SUM_W  = 62;  // signed working width before saturation
  localparam int HALF_Q = 32768;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_P2L    = 2'd2,
    OP_L2P    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// File: hdl/nonuniform_grid_coordinate_mapper_core.sv
// Clear, append and empty-grid queries go from accept straight to S_EMIT. Logical-to-physical
// uses the S_MUL0 and S_MUL1 multiplier steps (after a cell read when inside the grid);
// physical-to-logical uses a 57-step divider (after a binary search and a cell read when inside).
// Throughput: one item in work at a time; a new item is accepted only once the last has left S_EMIT.
// Reset (synchronous, rst_n low) empties the grid and clears periodic mode; the width and
// start memories are not cleared and are only read once written.
`include "nonuniform_grid_coordinate_mapper_core_macros.svh"

module nonuniform_grid_coordinate_mapper_core
  import ngcm_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_operation,
  input  logic [CW_W-1:0]        in_cell_width,
  input  logic signed [CO_W-1:0] in_coordinate,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [CO_W-1:0] out_mapped_value,
  output logic                   out_out_of_range,
  output logic [1:0]             out_status,
  output logic [10:0]            out_cell_count,
  output logic [CW_W-1:0]        out_minimum_width
);

  localparam int ADDR_W = $clog2(MAX_CELLS);
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  // Sum of MAX_CELLS widths each below 2^24 stays below 2^(24+ADDR_W).
  localparam int POS_W  = CW_W + ADDR_W;
  localparam int DCNT_W = $clog2(DNUM_W);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(CO_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_CELL_RD, S_CELL_USE,
    S_DIV, S_MUL0, S_MUL1, S_FIN, S_EMIT
  } state_t;

  state_t state_r;

  // Grid state. Both memories are written on append and read through a
  // registered read port; reads and writes belong to different items, so no
  // forwarding is needed.
  logic [CW_W-1:0]   w_mem [MAX_CELLS];
  logic [POS_W-1:0]  s_mem [MAX_CELLS];
  logic [CW_W-1:0]   rd_w_r;
  logic [POS_W-1:0]  rd_s_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  logic [CNT_W-1:0]  count_r;
  logic [POS_W-1:0]  total_r;
  logic [CW_W-1:0]   minw_r;
  logic [CW_W-1:0]   first_w_r;
  logic [CW_W-1:0]   last_w_r;
  logic              periodic_r;

  // Per-item working registers.
  op_t               op_r;
  logic signed [CO_W-1:0] p_r;
  logic [ADDR_W-1:0] lo_r, hi_r, mid_r;
  logic [DNUM_W-1:0] dnum_r;
  logic [H2_W-1:0]   den_r;
  logic [H2_W-1:0]   rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              num_zero_r;
  logic [CO_W-1:0]   a_r;
  logic [H2_W-1:0]   b_r;
  logic [ACC_W-1:0]  acc_r;
  logic              sh_r;
  logic              mul_sel_r;
  logic              neg_r;
  logic              oorq_r;
  logic signed [SUM_W-1:0] base_r;

  logic signed [CO_W-1:0] res_val_r;
  logic              res_oor_r;
  status_t           res_stat_r;

  logic                   out_valid_r;
  logic signed [CO_W-1:0] out_val_r;
  logic                   out_oor_r;
  status_t                out_stat_r;
  logic [10:0]            out_cnt_r;
  logic [CW_W-1:0]        out_minw_r;

  // Derived values.
  logic signed [SUM_W-1:0] coord_x, tot_x, top_x, upper_lim, p_x, rd_s_x;
  logic              lower, upper;
  logic [CO_W-1:0]   edge_mag;
  logic [H2_W-1:0]   front_h2, back_h2, edge_h2;
  logic [ADDR_W-1:0] mid, lo_nxt, hi_nxt;
  logic [H2_W:0]     rem_sh;
  logic              rem_ge;
  logic [H2_W-1:0]   rem_nxt;
  logic [DNUM_W-1:0] dnum_nxt;
  logic [CO_W-1:0]   cell_mag;
  logic [H2_W+19:0]  mul_part;
  logic [MAG_W-1:0]  fin_mag;
  logic signed [SUM_W-1:0] fin_mag_x, fin_sum;
  logic signed [CO_W-1:0]  fin_sat;

  always_comb begin
    coord_x   = SUM_W'(in_coordinate);
    tot_x     = SUM_W'(total_r);
    top_x     = SUM_W'(count_r) <<< 16;
    upper_lim = (op_t'(in_operation) == OP_P2L) ? tot_x : top_x;
    lower     = coord_x <= 0;
    upper     = coord_x >= upper_lim;
    edge_mag  = lower ? CO_W'(-coord_x) : CO_W'(coord_x - upper_lim);
    front_h2  = periodic_r ? H2_W'(first_w_r) + H2_W'(last_w_r) : H2_W'(first_w_r) << 1;
    back_h2   = periodic_r ? H2_W'(first_w_r) + H2_W'(last_w_r) : H2_W'(last_w_r) << 1;
    edge_h2   = lower ? front_h2 : back_h2;
    p_x       = SUM_W'(p_r);
    rd_s_x    = SUM_W'(rd_s_r);
    cell_mag  = CO_W'(p_x - rd_s_x);
    mid       = lo_r + ((hi_r - lo_r) >> 1);
  end

  // Binary search step: the end of cell mid is the start of cell mid+1.
  always_comb begin
    if (p_x <= rd_s_x) begin
      lo_nxt = lo_r;
      hi_nxt = mid_r;
    end else begin
      lo_nxt = mid_r + ADDR_W'(1);
      hi_nxt = hi_r;
    end
  end

  // One restoring divider step per cycle; quotient bits shift into dnum_r.
  always_comb begin
    rem_sh   = {rem_r, dnum_r[DNUM_W-1]};
    rem_ge   = rem_sh >= {1'b0, den_r};
    rem_nxt  = rem_ge ? H2_W'(rem_sh - {1'b0, den_r}) : rem_sh[H2_W-1:0];
    dnum_nxt = {dnum_r[DNUM_W-2:0], rem_ge};
  end

  // One 20 by 26 bit multiplier, used for the low and then the high bits of a_r.
  always_comb begin
    mul_part = (state_r == S_MUL1) ? a_r[CO_W-1:20] * b_r : a_r[19:0] * b_r;
  end

  always_comb begin
    if (mul_sel_r) begin
      fin_mag = sh_r ? MAG_W'(acc_r >> 17) : MAG_W'(acc_r >> 16);
    end else begin
      fin_mag = num_zero_r ? '0 : MAG_W'(dnum_r);
    end
    fin_mag_x = SUM_W'(fin_mag);
    fin_sum   = base_r + (neg_r ? -fin_mag_x : fin_mag_x);
    if (fin_sum > SAT_MAX) begin
      fin_sat = CO_W'(SAT_MAX);
    end else if (fin_sum < SAT_MIN) begin
      fin_sat = CO_W'(SAT_MIN);
    end else begin
      fin_sat = CO_W'(fin_sum);
    end
  end

  always_comb begin
    unique case (state_r)
      S_SRCH_RD: rd_addr = mid + ADDR_W'(1);
      default:   rd_addr = lo_r;
    endcase
    mem_we = (state_r == S_IDLE) && in_valid && (op_t'(in_operation) == OP_APPEND) &&
             (count_r < CNT_W'(MAX_CELLS));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      w_mem[count_r[ADDR_W-1:0]] <= in_cell_width;
      s_mem[count_r[ADDR_W-1:0]] <= total_r;
    end
    rd_w_r <= w_mem[rd_addr];
    rd_s_r <= s_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      minw_r      <= '0;
      periodic_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        periodic_r <= cfg_wdata;
      end
      // The output register empties when its item leaves, unless S_EMIT
      // refills it at the same edge.
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op_t'(in_operation);
            p_r        <= in_coordinate;
            res_val_r  <= '0;
            res_oor_r  <= 1'b0;
            res_stat_r <= ST_OK;
            state_r    <= S_EMIT;
            priority if (op_t'(in_operation) == OP_CLEAR) begin
              count_r <= '0;
              total_r <= '0;
              minw_r  <= '0;
            end else if (op_t'(in_operation) == OP_APPEND) begin
              if (count_r >= CNT_W'(MAX_CELLS)) begin
                res_stat_r <= ST_FULL;
              end else begin
                total_r <= total_r + POS_W'(in_cell_width);
                if (count_r == '0 || in_cell_width < minw_r) begin
                  minw_r <= in_cell_width;
                end
                if (count_r == '0) begin
                  first_w_r <= in_cell_width;
                end
                last_w_r <= in_cell_width;
                count_r  <= count_r + CNT_W'(1);
              end
            end else if (count_r == '0) begin
              res_stat_r <= ST_EMPTY;
              res_oor_r  <= 1'b1;
            end else if (lower || upper) begin
              // Extrapolation past either end with the end half-width.
              neg_r  <= lower;
              sh_r   <= 1'b1;
              if (lower) begin
                base_r <= '0;
              end else if (op_t'(in_operation) == OP_P2L) begin
                base_r <= top_x;
              end else begin
                base_r <= tot_x;
              end
              if (op_t'(in_operation) == OP_P2L) begin
                dnum_r     <= DNUM_W'(edge_mag) << 17;
                den_r      <= edge_h2;
                num_zero_r <= edge_mag == '0;
                rem_r      <= '0;
                dcnt_r     <= DCNT_W'(DNUM_W - 1);
                mul_sel_r  <= 1'b0;
                oorq_r     <= 1'b1;
                state_r    <= S_DIV;
              end else begin
                a_r       <= edge_mag;
                b_r       <= edge_h2;
                mul_sel_r <= 1'b1;
                oorq_r    <= 1'b0;
                res_oor_r <= lower ? (coord_x <= -SUM_W'(HALF_Q))
                                   : (edge_mag >= CO_W'(HALF_Q));
                state_r   <= S_MUL0;
              end
            end else if (op_t'(in_operation) == OP_P2L) begin
              lo_r    <= '0;
              hi_r    <= ADDR_W'(count_r - CNT_W'(1));
              state_r <= (count_r > CNT_W'(1)) ? S_SRCH_RD : S_CELL_RD;
            end else begin
              // Inside the grid: cell index and fraction come from the bits.
              lo_r    <= in_coordinate[16 +: ADDR_W];
              a_r     <= CO_W'(in_coordinate[15:0]);
              state_r <= S_CELL_RD;
            end
          end
        end
        S_SRCH_RD: begin
          mid_r   <= mid;
          state_r <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          lo_r    <= lo_nxt;
          hi_r    <= hi_nxt;
          state_r <= (lo_nxt < hi_nxt) ? S_SRCH_RD : S_CELL_RD;
        end
        S_CELL_RD: begin
          state_r <= S_CELL_USE;
        end
        S_CELL_USE: begin
          neg_r  <= 1'b0;
          oorq_r <= 1'b0;
          sh_r   <= 1'b0;
          if (op_r == OP_P2L) begin
            base_r     <= SUM_W'(lo_r) <<< 16;
            dnum_r     <= DNUM_W'(cell_mag) << 16;
            den_r      <= H2_W'(rd_w_r);
            num_zero_r <= cell_mag == '0;
            rem_r      <= '0;
            dcnt_r     <= DCNT_W'(DNUM_W - 1);
            mul_sel_r  <= 1'b0;
            state_r    <= S_DIV;
          end else begin
            base_r    <= rd_s_x;
            b_r       <= H2_W'(rd_w_r);
            mul_sel_r <= 1'b1;
            state_r   <= S_MUL0;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          dnum_r <= dnum_nxt;
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == '0) begin
            state_r <= S_FIN;
          end
        end
        S_MUL0: begin
          acc_r   <= ACC_W'(mul_part);
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          acc_r   <= acc_r + (ACC_W'(mul_part) << 20);
          state_r <= S_FIN;
        end
        S_FIN: begin
          res_val_r <= fin_sat;
          if (oorq_r) begin
            res_oor_r <= fin_mag >= MAG_W'(HALF_Q);
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_oor_r   <= res_oor_r;
            out_stat_r  <= res_stat_r;
            out_cnt_r   <= 11'(count_r);
            out_minw_r  <= minw_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_mapped_value  = out_val_r;
  assign out_out_of_range  = out_oor_r;
  assign out_status        = out_stat_r;
  assign out_cell_count    = out_cnt_r;
  assign out_minimum_width = out_minw_r;

  // An accepted item leaves the block busy in the cycle after it is accepted.
  `NGCM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // The cell count never passes the capacity.
  `NGCM_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_CELLS))
  // A result that finds the output slot free is presented on the next cycle.
  `NGCM_ASSERT_NEXT(a_emit_lands, state_r == S_EMIT && (!out_valid_r || out_ready),
                    out_valid_r && in_ready)

endmodule

// File: tb/sv/tb_nonuniform_grid_coordinate_mapper_core.sv
module tb_nonuniform_grid_coordinate_mapper_core;
  import ngcm_pkg::*;

  // The saturation bounds of the 40-bit signed Q.16 result.
  localparam longint MAXV = 64'sd549755813887;
  localparam longint MINV = -64'sd549755813888;
  localparam int NCELLS = 1024;
  // Idle cycles without any item accepted on either side before we give up.
  // The limit lies well above the slowest item and the longest receiver
  // hold-off, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic signed [CO_W-1:0] value;
    logic                   oor;
    logic [1:0]             status;
    logic [10:0]            count;
    logic [CW_W-1:0]        minw;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_CLEAR;
  logic [CW_W-1:0] in_cell_width = '0;
  logic signed [CO_W-1:0] in_coordinate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CO_W-1:0] out_mapped_value;
  logic out_out_of_range;
  logic [1:0] out_status;
  logic [10:0] out_cell_count;
  logic [CW_W-1:0] out_minimum_width;

  nonuniform_grid_coordinate_mapper_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_cell_width(in_cell_width),
    .in_coordinate(in_coordinate),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_mapped_value(out_mapped_value), .out_out_of_range(out_out_of_range),
    .out_status(out_status), .out_cell_count(out_cell_count),
    .out_minimum_width(out_minimum_width)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Our own copy of the grid: widths, start positions, length, count and the
  // smallest width, plus the periodic mode register.
  logic [CW_W-1:0] grid_width [NCELLS];
  longint unsigned grid_start [NCELLS];
  longint unsigned grid_length = 0;
  int unsigned grid_cells = 0;
  logic [CW_W-1:0] grid_min_width = '0;
  bit periodic = 1'b0;

  grid_result_t pending_results[$];
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int stall_left = 0;
  int hold_cycles = 0;   // long receiver hold-off requested by a test
  bit no_idle = 1'b0;    // stretches where neither side idles

  function automatic longint clamp40(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  // Shifted division truncated toward zero; a zero divisor saturates.
  function automatic longint div_toward_zero(longint num, int sh, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    if (num == 0) return 0;
    if (den == 0) return (num > 0) ? MAXV : MINV;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag << sh) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Product with a doubled half-width (17 fraction bits), truncated toward zero.
  function automatic longint scale_by_half_width(longint v, longint unsigned h2);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = (mag >> 17) * h2 + (((mag & 64'h1FFFF) * h2) >> 17);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Doubled end half-widths: edge cells, or first plus last in periodic mode.
  function automatic longint unsigned front_half2();
    longint unsigned a = grid_width[0];
    longint unsigned b = grid_width[grid_cells-1];
    return periodic ? a + b : 2 * a;
  endfunction

  function automatic longint unsigned back_half2();
    longint unsigned a = grid_width[0];
    longint unsigned b = grid_width[grid_cells-1];
    return periodic ? a + b : 2 * b;
  endfunction

  function automatic longint unsigned cell_end(int unsigned i);
    return (i + 1 < grid_cells) ? grid_start[i+1] : grid_length;
  endfunction

  function automatic longint physical_to_logical(longint p, output logic oor);
    longint tot = longint'(grid_length);
    longint q;
    int unsigned lo, hi, mid;
    oor = 1'b0;
    if (p <= 0) begin
      q = div_toward_zero(p, 17, front_half2());
      oor = (q <= -32768);
      return clamp40(q);
    end
    if (p >= tot) begin
      q = div_toward_zero(p - tot, 17, back_half2());
      oor = (q >= 32768);
      return clamp40(longint'(grid_cells) * 65536 + q);
    end
    lo = 0;
    hi = grid_cells - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (p <= longint'(cell_end(mid))) hi = mid;
      else lo = mid + 1;
    end
    q = div_toward_zero(p - longint'(grid_start[lo]), 16, grid_width[lo]);
    return clamp40(longint'(lo) * 65536 + q);
  endfunction

  function automatic longint logical_to_physical(longint l, output logic oor);
    longint top = longint'(grid_cells) * 65536;
    longint unsigned i, fr, w;
    oor = 1'b0;
    if (l <= 0) begin
      oor = (l <= -32768);
      return clamp40(scale_by_half_width(l, front_half2()));
    end
    if (l >= top) begin
      oor = (l - top >= 32768);
      return clamp40(longint'(grid_length) + scale_by_half_width(l - top, back_half2()));
    end
    i = longint'(l) >> 16;
    fr = l & 64'hFFFF;
    if (i >= grid_cells) i = grid_cells - 1;
    w = grid_width[i];
    return clamp40(longint'(grid_start[i]) + longint'((w * fr) >> 16));
  endfunction

  // Applies one item to our grid copy and returns the result it should give.
  function automatic grid_result_t predict_grid_item(op_t op, logic [CW_W-1:0] w,
                                                     logic signed [CO_W-1:0] c);
    grid_result_t r;
    longint mapped = 0;
    logic oor = 1'b0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        grid_cells = 0;
        grid_length = 0;
        grid_min_width = '0;
      end
      OP_APPEND: begin
        if (grid_cells >= NCELLS) begin
          r.status = ST_FULL;
        end else begin
          grid_width[grid_cells] = w;
          grid_start[grid_cells] = grid_length;
          grid_length += w;
          if (grid_cells == 0 || w < grid_min_width) grid_min_width = w;
          grid_cells++;
        end
      end
      default: begin
        if (grid_cells == 0) begin
          r.status = ST_EMPTY;
          oor = 1'b1;
        end else if (op == OP_P2L) begin
          mapped = physical_to_logical(longint'(c), oor);
        end else begin
          mapped = logical_to_physical(longint'(c), oor);
        end
      end
    endcase
    r.value = mapped[CO_W-1:0];
    r.oor = oor;
    r.count = grid_cells[10:0];
    r.minw = grid_min_width;
    return r;
  endfunction

  // Item gaps: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends one item. The valid stays high from the previous item when there is
  // no gap, so it is never lowered and raised within the same step.
  task automatic send_item(op_t op, logic [CW_W-1:0] w, logic signed [CO_W-1:0] c);
    int g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_operation <= op;
    in_cell_width <= w;
    in_coordinate <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_grid_item(op, w, c));
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_periodic(bit mode);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    periodic = mode;
    @(posedge clk);
  endtask

  function automatic logic [CW_W-1:0] random_width();
    int bits = $urandom_range(1, CW_W);
    int unsigned top = (32'd1 << bits) - 1;
    return CW_W'($urandom_range(1, top));
  endfunction

  function automatic longint random_span(longint lo, longint hi);
    longint unsigned r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  function automatic logic signed [CO_W-1:0] random_coord();
    return {8'($urandom_range(0, 255)), $urandom};
  endfunction

  // Picks a coordinate for a query on the current grid: mostly inside or
  // near the grid, some at the half-cell borders, some anywhere at all.
  function automatic logic signed [CO_W-1:0] query_coord(op_t op);
    int r = $urandom_range(0, 99);
    longint span = (op == OP_P2L) ? longint'(grid_length) : longint'(grid_cells) * 65536;
    longint pick;
    if (r < 15) return random_coord();
    if (r < 35) begin
      pick = ($urandom_range(0, 1) ? span : 0) + random_span(-40000, 40000);
      if ($urandom_range(0, 3) == 0 && op == OP_L2P)
        pick = ($urandom_range(0, 1) ? span + 32768 : -32768) - $urandom_range(0, 1);
      return CO_W'(clamp40(pick));
    end
    return CO_W'(clamp40(random_span(-span / 2 - 65536, span + span / 2 + 65536)));
  endfunction

  // Edges of the fields, empty-grid queries, zero-width edge cells and
  // saturation on both ends of the coordinate range.
  task automatic test_directed();
    logic signed [CO_W-1:0] cmin = {1'b1, {(CO_W-1){1'b0}}};
    logic signed [CO_W-1:0] cmax = {1'b0, {(CO_W-1){1'b1}}};
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_P2L, '0, '0);
    send_item(OP_L2P, '0, 40'sd5);
    send_item(OP_APPEND, 24'hFFFFFF, '0);
    send_item(OP_APPEND, 24'd1, '0);
    send_item(OP_APPEND, 24'h010000, '0);
    send_item(OP_P2L, '0, cmin);
    send_item(OP_P2L, '0, cmax);
    send_item(OP_P2L, '0, 40'sh8000);
    send_item(OP_P2L, '0, 40'sh1000000);
    send_item(OP_L2P, '0, -40'sd32768);
    send_item(OP_L2P, '0, -40'sd32767);
    send_item(OP_L2P, '0, cmax);
    send_item(OP_L2P, '0, cmin);
    send_item(OP_L2P, '0, 40'sd229375);
    send_item(OP_L2P, '0, 40'sd229376);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_P2L, '0, cmax);
    send_item(OP_L2P, '0, 40'sd300000);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_P2L, '0, -40'sd5);
    send_item(OP_P2L, '0, '0);
    write_periodic(1'b1);
    send_item(OP_P2L, '0, -40'sd5);
    send_item(OP_APPEND, 24'h020000, '0);
    send_item(OP_P2L, '0, 40'sd400000);
    write_periodic(1'b0);
  endtask

  // Fills the grid to capacity, tries two more appends, then queries the full
  // grid in both modes.
  task automatic test_grid_full();
    send_item(OP_CLEAR, '0, '0);
    for (int i = 0; i < NCELLS + 2; i++) send_item(OP_APPEND, random_width(), '0);
    for (int m = 0; m < 2; m++) begin
      write_periodic(m[0]);
      for (int i = 0; i < 20; i++) begin
        op_t op = $urandom_range(0, 1) ? OP_P2L : OP_L2P;
        send_item(op, random_width(), query_coord(op));
      end
    end
  endtask

  // Phases of clear, a few appends and many queries, with the mode changed
  // between phases and some stray items mixed in.
  task automatic test_random_phases(int budget);
    int start = items_sent;
    int k, q;
    op_t op;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 2) == 0) write_periodic(1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 4) == 0);
      send_item(OP_CLEAR, random_width(), random_coord());
      k = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 64);
      for (int i = 0; i < k; i++) send_item(OP_APPEND, random_width(), random_coord());
      q = $urandom_range(10, 30);
      for (int i = 0; i < q; i++) begin
        int r = $urandom_range(0, 99);
        if (r < 3) send_item(OP_CLEAR, random_width(), random_coord());
        else if (r < 8) send_item(OP_APPEND, random_width(), random_coord());
        else begin
          op = $urandom_range(0, 1) ? OP_P2L : OP_L2P;
          send_item(op, random_width(), query_coord(op));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // input stalls; then the sender waits for everything to come back.
  task automatic test_backpressure();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_APPEND, random_width(), '0);
    send_item(OP_APPEND, random_width(), '0);
    hold_cycles = 300;
    for (int i = 0; i < 12; i++) begin
      op_t op = $urandom_range(0, 1) ? OP_P2L : OP_L2P;
      send_item(op, '0, query_coord(op));
    end
    drain_results();
  endtask

  // Receiver: random stalls, plus the long hold-off when a test asks.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Compares each result item with the oldest expectation.
  always @(posedge clk) begin
    grid_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item: value %0d", out_mapped_value);
      end else begin
        e = pending_results.pop_front();
        results_checked++;
        if (e.value !== out_mapped_value || e.oor !== out_out_of_range ||
            e.status !== out_status || e.count !== out_cell_count ||
            e.minw !== out_minimum_width) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp value %0d oor %0b status %0d cells %0d minw %0h, got %0d %0b %0d %0d %0h",
                     e.value, e.oor, e.status, e.count, e.minw, out_mapped_value,
                     out_out_of_range, out_status, out_cell_count, out_minimum_width);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_grid_full();
    test_backpressure();
    test_random_phases(800);
    drain_results();
    repeat (100) @(posedge clk);
    $display("Covered %0d items (%0d results): empty and full grid, edge extrapolation,",
             items_sent, results_checked);
    $display("zero-width edges, saturation, both modes, random stalls and a long hold-off.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
